FILE: src/arlp_pkg.sv
// Package for the account record line parser: phase codes, status codes, widths.
// No dependencies.
package arlp_pkg;

    localparam int MaxEntriesDef = 16;
    localparam int NameBytesDef  = 32;

    localparam logic [7:0] ChHash  = 8'h23;
    localparam logic [7:0] ChColon = 8'h3A;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;

    localparam logic [30:0] NumMax = 31'h7FFF_FFFF;

    typedef enum logic [7:0] {
        PH_START   = 8'b0000_0001,
        PH_LEAD    = 8'b0000_0010,
        PH_NAME    = 8'b0000_0100,
        PH_UID     = 8'b0000_1000,
        PH_GID     = 8'b0001_0000,
        PH_TAIL    = 8'b0010_0000,
        PH_COMMENT = 8'b0100_0000,
        PH_BREAK   = 8'b1000_0000
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_MAL  = 3'd1,
        ST_NLEN = 3'd2,
        ST_NUM  = 3'd3,
        ST_FULL = 3'd4,
        ST_DUP  = 3'd5
    } t_status;

    // Control word broadcast from the line parser to every table cell.
    typedef struct packed {
        logic       clear;      // empty the table (new buffer)
        logic       line_start; // a new line begins: reset match tracking
        logic       name_byte;  // a name byte is stored this cycle
        logic [7:0] data;       // the name byte
        logic       commit;     // the line is accepted: write the free cell
    } t_cell_ctl;

endpackage

FILE: src/arlp_cell.sv
// One table cell: holds one stored name and compares it with the incoming name.
// Depends on arlp_pkg.
module arlp_cell #(
    parameter int NameBytes = arlp_pkg::NameBytesDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  arlp_pkg::t_cell_ctl i_ctl,
    input  logic [$clog2(NameBytes+1)-1:0] i_cur_len,
    input  logic                i_prev_full,   // all cells before this one hold an entry
    input  logic                i_prev_dup,    // an earlier cell matches the current name
    output logic                o_full,
    output logic                o_dup
);
    import arlp_pkg::*;

    localparam int LenW = $clog2(NameBytes + 1);
    localparam int IdxW = (NameBytes > 1) ? $clog2(NameBytes) : 1;

    logic [7:0]      r_name [NameBytes];
    logic [LenW-1:0] r_len;
    logic            r_used;
    logic            r_match;
    logic [LenW-1:0] r_pos;
    logic            n_write;

    // The first free cell takes the committed name.
    assign n_write = i_ctl.commit && i_prev_full && !r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_used <= 1'b0;
        end else if (n_write) begin
            r_used <= 1'b1;
        end
    end

    // Stored bytes and length: written on commit from the live compare? No:
    // the name is captured byte by byte into a shadow while the line streams,
    // and the used flag makes it visible only once the line is committed.
    always_ff @(posedge i_clk) begin
        if (!r_used && i_ctl.name_byte && i_cur_len < LenW'(NameBytes)) begin
            r_name[i_cur_len[IdxW-1:0]] <= i_ctl.data;
        end
        if (n_write) begin
            r_len <= i_cur_len;
        end
    end

    // The first name byte of a line can arrive in the same cycle as the line start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b1;
            r_pos   <= '0;
        end else if (i_ctl.name_byte && i_cur_len < LenW'(NameBytes)) begin
            if (r_used && r_name[i_cur_len[IdxW-1:0]] != i_ctl.data) begin
                r_match <= 1'b0;
            end else if (i_ctl.line_start) begin
                r_match <= 1'b1;
            end
            r_pos <= i_ctl.line_start ? LenW'(1) : r_pos + 1'b1;
        end else if (i_ctl.line_start) begin
            r_match <= 1'b1;
            r_pos   <= '0;
        end
    end

    assign o_full = i_prev_full && r_used;
    assign o_dup  = i_prev_dup || (r_used && r_match && r_len == i_cur_len && r_pos == i_cur_len);

endmodule

FILE: src/arlp_line.sv
// Line parser: phase machine, digit accumulators, counters and result word.
// Depends on arlp_pkg.
module arlp_line #(
    parameter int MaxEntries = arlp_pkg::MaxEntriesDef,
    parameter int NameBytes  = arlp_pkg::NameBytesDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    input  logic                i_tab_full,
    input  logic                i_tab_dup,
    input  logic [$clog2(MaxEntries+1)-1:0] i_total,
    output arlp_pkg::t_cell_ctl o_ctl,
    output logic [$clog2(NameBytes+1)-1:0] o_cur_len,
    output logic                o_got,
    output logic [2:0]          o_status,
    output logic [15:0]         o_line,
    output logic [$clog2(MaxEntries+1)-1:0] o_slot,
    output logic [30:0]         o_uid,
    output logic [30:0]         o_gid,
    output logic [$clog2(MaxEntries+1)-1:0] o_held
);
    import arlp_pkg::*;

    localparam int LenW = $clog2(NameBytes + 1);
    localparam int TotW = $clog2(MaxEntries + 1);

    t_phase          r_ph, n_ph, w_ph;
    logic [15:0]     r_line, w_line;
    logic [LenW-1:0] r_len, n_len, w_len;
    logic [30:0]     r_uid, n_uid, w_uid, r_gid, n_gid, w_gid;
    logic            r_ua, r_ub, r_ga, r_gb, n_ua, n_ub, n_ga, n_gb, w_ua, w_ub, w_ga, w_gb;
    logic            w_brk, w_begin, w_fin, w_name, w_commit;
    logic [34:0]     w_prod;
    logic [2:0]      w_status;

    // Accumulate one decimal digit; a 31-bit value times ten plus the digit fits in 35 bits.
    function automatic logic [34:0] mul10(input logic [30:0] a, input logic [3:0] d);
        mul10 = 35'({a, 3'b000}) + 35'({a, 1'b0}) + 35'(d);
    endfunction

    always_comb begin
        w_brk   = (i_byte == ChLf) || (i_byte == ChCr);
        w_begin = 1'b0;
        w_ph    = r_ph;
        if (r_ph == PH_START || r_ph == PH_BREAK) begin
            if (!w_brk) begin
                w_begin = 1'b1;
                w_ph    = PH_LEAD;
            end else if (r_ph == PH_START) begin
                w_begin = 1'b1;
                w_ph    = PH_BREAK;
            end
        end
        w_line = (w_begin && r_line != 16'hFFFF) ? r_line + 16'd1 : r_line;
        w_len  = w_begin ? '0 : r_len;
        w_uid  = w_begin ? '0 : r_uid;
        w_gid  = w_begin ? '0 : r_gid;
        w_ua = w_begin ? 1'b0 : r_ua;  w_ub = w_begin ? 1'b0 : r_ub;
        w_ga = w_begin ? 1'b0 : r_ga;  w_gb = w_begin ? 1'b0 : r_gb;

        n_ph = w_ph; n_len = w_len; n_uid = w_uid; n_gid = w_gid;
        n_ua = w_ua; n_ub = w_ub; n_ga = w_ga; n_gb = w_gb;
        w_fin = 1'b0; w_name = 1'b0; w_prod = '0;
        if (w_ph != PH_BREAK) begin
            if (w_brk) begin
                w_fin = 1'b1;
                n_ph  = PH_BREAK;
            end else begin
                unique case (w_ph)
                    PH_LEAD: begin
                        if (i_byte == ChSpace || i_byte == ChTab) begin
                        end else if (i_byte == ChHash) begin
                            n_ph = PH_COMMENT;
                        end else if (i_byte == ChColon) begin
                            n_ph = PH_UID;
                        end else begin
                            w_name = 1'b1;
                            n_ph   = PH_NAME;
                        end
                    end
                    PH_NAME: begin
                        if (i_byte == ChColon) n_ph = PH_UID;
                        else w_name = 1'b1;
                    end
                    PH_UID: begin
                        if (i_byte == ChColon) begin
                            n_ph = PH_GID;
                        end else begin
                            n_ua = 1'b1;
                            w_prod = mul10(w_uid, i_byte[3:0]);
                            if (i_byte < ChZero || i_byte > ChNine) n_ub = 1'b1;
                            else if (!w_ub) begin
                                if (w_prod > 35'(NumMax)) n_ub = 1'b1;
                                else n_uid = w_prod[30:0];
                            end
                        end
                    end
                    PH_GID: begin
                        if (i_byte == ChColon) begin
                            n_ph = PH_TAIL;
                        end else begin
                            n_ga = 1'b1;
                            w_prod = mul10(w_gid, i_byte[3:0]);
                            if (i_byte < ChZero || i_byte > ChNine) n_gb = 1'b1;
                            else if (!w_gb) begin
                                if (w_prod > 35'(NumMax)) n_gb = 1'b1;
                                else n_gid = w_prod[30:0];
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (w_name && w_len < LenW'(NameBytes)) n_len = w_len + 1'b1;
        if (i_last && !w_fin && n_ph != PH_START && n_ph != PH_BREAK) w_fin = 1'b1;

        // Status of the line that ends now; the state seen is the one before
        // this byte's update only for the break case, else after it.
        o_got    = 1'b0;
        w_status = ST_OK;
        w_commit = 1'b0;
        if (w_fin) begin
            t_phase fp;
            logic fa, fub, fga, fgb;
            logic [LenW-1:0] fl;
            fp  = w_brk ? w_ph : n_ph;
            fl  = w_brk ? w_len : n_len;
            fa  = w_brk ? w_ua : n_ua;   fub = w_brk ? w_ub : n_ub;
            fga = w_brk ? w_ga : n_ga;   fgb = w_brk ? w_gb : n_gb;
            if (fp != PH_LEAD && fp != PH_COMMENT) begin
                o_got = 1'b1;
                if (fp == PH_NAME || fp == PH_UID) w_status = ST_MAL;
                else if (fl == '0 || fl >= LenW'(NameBytes)) w_status = ST_NLEN;
                else if (!fa || fub || !fga || fgb) w_status = ST_NUM;
                else if (i_tab_full) w_status = ST_FULL;
                else if (i_tab_dup) w_status = ST_DUP;
                else w_commit = 1'b1;
            end
        end
        if (i_last) n_ph = PH_START;
    end

    assign o_status  = w_status;
    assign o_line    = w_line;
    assign o_slot    = w_commit ? i_total : '0;
    assign o_uid     = (w_status == ST_OK || w_status == ST_FULL || w_status == ST_DUP)
                       ? (w_brk ? w_uid : n_uid) : '0;
    assign o_gid     = (w_status == ST_OK || w_status == ST_FULL || w_status == ST_DUP)
                       ? (w_brk ? w_gid : n_gid) : '0;
    assign o_held    = w_commit ? TotW'(i_total + 1'b1) : i_total;
    assign o_cur_len = w_len;

    assign o_ctl.clear      = i_step && i_last;
    assign o_ctl.line_start = i_step && w_begin;
    assign o_ctl.name_byte  = i_step && w_name;
    assign o_ctl.data       = i_byte;
    assign o_ctl.commit     = i_step && w_commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_START; r_line <= '0; r_len <= '0;
            r_uid <= '0; r_gid <= '0;
            r_ua <= 1'b0; r_ub <= 1'b0; r_ga <= 1'b0; r_gb <= 1'b0;
        end else if (i_step) begin
            r_ph <= n_ph; r_len <= n_len; r_uid <= n_uid; r_gid <= n_gid;
            r_ua <= n_ua; r_ub <= n_ub; r_ga <= n_ga; r_gb <= n_gb;
            r_line <= i_last ? 16'd0 : w_line;
        end
    end

endmodule

FILE: src/account_record_line_parser.sv
// Top level of the account record line parser: line parser, chain of table cells,
// output register. Depends on arlp_pkg, arlp_line and arlp_cell.
//
//  channel | signals                                   | direction
//  input   | i_valid o_ready i_text_byte i_buffer_end  | in
//  result  | o_valid i_ready o_line_status ..          | out
//
// One byte word is taken per cycle while the output register is empty or being drained.
// A line's result word is registered at the edge that takes the byte ending the line
// and is offered from the next cycle on.
// Reset clears the phase, counters, table use flags and the output valid.
// A stall on the result side holds input ready low until the word is taken.
module account_record_line_parser #(
    parameter int MaxEntries = arlp_pkg::MaxEntriesDef,
    parameter int NameBytes  = arlp_pkg::NameBytesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_buffer_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_line_status,
    output logic [15:0] o_line_number,
    output logic [3:0]  o_entry_slot,
    output logic [30:0] o_user_number,
    output logic [30:0] o_group_number,
    output logic [4:0]  o_entries_held,
    output logic        o_buffer_done
);
    import arlp_pkg::*;

    localparam int LenW = $clog2(NameBytes + 1);
    localparam int TotW = $clog2(MaxEntries + 1);

    t_cell_ctl       w_ctl;
    logic [LenW-1:0] w_len;
    logic            w_step, w_got;
    logic [MaxEntries:0] w_full, w_dup;
    logic [TotW-1:0] w_total, w_slot, w_held;
    logic [2:0]      w_status;
    logic [15:0]     w_line;
    logic [30:0]     w_uid, w_gid;
    logic            r_valid;

    assign o_ready = !r_valid || i_ready;
    assign w_step  = i_valid && o_ready;

    arlp_line #(.MaxEntries(MaxEntries), .NameBytes(NameBytes)) u_line (
        .i_clk, .i_rst_n, .i_step(w_step), .i_byte(i_text_byte), .i_last(i_buffer_end),
        .i_tab_full(w_full[MaxEntries]), .i_tab_dup(w_dup[MaxEntries]), .i_total(w_total),
        .o_ctl(w_ctl), .o_cur_len(w_len), .o_got(w_got), .o_status(w_status),
        .o_line(w_line), .o_slot(w_slot), .o_uid(w_uid), .o_gid(w_gid), .o_held(w_held)
    );

    assign w_full[0] = 1'b1;
    assign w_dup[0]  = 1'b0;

    always_comb begin
        w_total = '0;
        for (int k = 0; k < MaxEntries; k++) begin
            if (w_full[k+1]) w_total = TotW'(k + 1);
        end
    end

    for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
        arlp_cell #(.NameBytes(NameBytes)) u_cell (
            .i_clk, .i_rst_n, .i_ctl(w_ctl), .i_cur_len(w_len),
            .i_prev_full(w_full[g]), .i_prev_dup(w_dup[g]),
            .o_full(w_full[g+1]), .o_dup(w_dup[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= w_step && w_got;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_got) begin
            o_line_status  <= w_status;
            o_line_number  <= w_line;
            o_entry_slot   <= 4'(w_slot);
            o_user_number  <= w_uid;
            o_group_number <= w_gid;
            o_entries_held <= 5'(w_held);
            o_buffer_done  <= i_buffer_end;
        end
    end

    assign o_valid = r_valid;

    // A held word may not be overwritten.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(o_line_status))
        else $error("result word lost under stall");
    // Accepted entries always count up from the slot written.
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && o_line_status == ST_OK |-> o_entries_held == 5'(o_entry_slot) + 5'd1)
        else $error("slot and entry count disagree");
    // Table occupancy never exceeds its depth.
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_total <= TotW'(MaxEntries))
        else $error("table overfilled");

endmodule
